[rtl/easpf_pkg.sv]
// Shared constants, codes and types for the eight-axis step pulse framer.
package easpf_pkg;

  localparam int NUM_MOTORS_DEFAULT = 8;

  localparam int OP_W     = 2;
  localparam int MOTOR_W  = 3;
  localparam int STEP_W   = 16;
  localparam int PERIOD_W = 16;
  localparam int COUNT_W  = 32;
  localparam int WORD_W   = 16;
  localparam int MASK_W   = 8;
  localparam int POS_W    = $clog2(WORD_W);
  localparam int MAG_W    = STEP_W + 1;
  localparam int PROD_W   = MAG_W + PERIOD_W;
  localparam int STEP_CNT_W = $clog2(COUNT_W);

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_TICK_CH,
    ST_TICK_WAIT,
    ST_TICK_END,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                start;
    logic [COUNT_W-1:0]  dividend;
    logic [PERIOD_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_rsp_t;

endpackage

[rtl/eight_axis_step_pulse_framer.sv]
// Top level of the eight-axis step pulse framer: sequencer, channel state and result register.
//
//   channel | handshake                 | payload
//   item    | item_valid / item_stall   | op, motor, step_count, period
//   result  | result_valid / result_stall| frame_word, frame_valid, run_done, active_mask
//
// A load passes through the load state, and a start scans every channel in turn.
// A tick during a run checks each channel with frames left in the shared
// bit-serial remainder unit and waits for each check to finish; other channels are stepped
// without a check. Any other item goes straight to the finish state.
// A new transaction is taken while the previous result still waits in the result register.
// Reset is synchronous and leaves every period at one and every count at zero.
module eight_axis_step_pulse_framer #(
  parameter int NUM_MOTORS = easpf_pkg::NUM_MOTORS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [easpf_pkg::OP_W-1:0]          op,
  input  logic [easpf_pkg::MOTOR_W-1:0]       motor,
  input  logic signed [easpf_pkg::STEP_W-1:0] step_count,
  input  logic [easpf_pkg::PERIOD_W-1:0]      period,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [easpf_pkg::WORD_W-1:0]        frame_word,
  output logic                                frame_valid,
  output logic                                run_done,
  output logic [easpf_pkg::MASK_W-1:0]        active_mask
);

  localparam int IW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  easpf_pkg::state_t state, state_next;

  logic [easpf_pkg::OP_W-1:0]     cur_op;
  logic [easpf_pkg::MOTOR_W-1:0]  cur_motor;
  logic [easpf_pkg::STEP_W-1:0]   cur_steps;
  logic [easpf_pkg::PERIOD_W-1:0] cur_period;

  logic [easpf_pkg::PERIOD_W-1:0] toggle_period [NUM_MOTORS];
  logic [easpf_pkg::COUNT_W-1:0]  frames_left   [NUM_MOTORS];
  logic [NUM_MOTORS-1:0]          direction_bits;
  logic [NUM_MOTORS-1:0]          motor_mask;
  logic [easpf_pkg::COUNT_W-1:0]  frame_counter;
  logic [easpf_pkg::WORD_W-1:0]   word_reg;

  logic [IW-1:0]                  idx;
  logic [easpf_pkg::COUNT_W-1:0]  scan_max;
  logic                           flag_valid;
  logic                           flag_done;

  logic                           accept;
  logic                           out_free;
  logic                           last_ch;
  logic                           ch_need;
  logic                           motor_ok;
  logic [IW-1:0]                  ld_ch;
  logic [easpf_pkg::PERIOD_W-1:0] eff_period;
  logic [easpf_pkg::MAG_W-1:0]    mag;
  logic [easpf_pkg::PROD_W-1:0]   prod;
  logic [easpf_pkg::COUNT_W-1:0]  scan_val;
  logic [easpf_pkg::POS_W-1:0]    dir_pos;
  logic [easpf_pkg::POS_W-1:0]    step_pos;
  logic                           apply_ch;
  logic                           toggle_hit;
  logic                           result_load;

  easpf_pkg::mod_req_t mod_req;
  easpf_pkg::mod_rsp_t mod_rsp;

  easpf_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  always_comb begin
    accept     = item_valid && !item_stall;
    out_free   = !result_valid || !result_stall;
    last_ch    = (idx == IW'(NUM_MOTORS - 1));
    ch_need    = (frames_left[idx] != '0) && (toggle_period[idx] != '0);
    motor_ok   = ({29'd0, cur_motor} < 32'(NUM_MOTORS));
    ld_ch      = cur_motor[IW-1:0];
    eff_period = (cur_period != '0) ? cur_period : toggle_period[ld_ch];
    mag        = cur_steps[easpf_pkg::STEP_W-1]
                 ? easpf_pkg::MAG_W'(18'h10000 - {2'b00, cur_steps})
                 : {1'b0, cur_steps};
    prod       = easpf_pkg::PROD_W'(mag) * easpf_pkg::PROD_W'(eff_period);
    scan_val   = (frames_left[idx] > scan_max) ? frames_left[idx] : scan_max;
    dir_pos    = easpf_pkg::POS_W'({idx, 1'b0});
    step_pos   = dir_pos + 1'b1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      easpf_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            easpf_pkg::OP_LOAD:  state_next = easpf_pkg::ST_LOAD;
            easpf_pkg::OP_START: state_next = easpf_pkg::ST_SCAN;
            easpf_pkg::OP_TICK: begin
              state_next = (frame_counter != '0) ? easpf_pkg::ST_TICK_CH
                                                 : easpf_pkg::ST_FINISH;
            end
            default: state_next = easpf_pkg::ST_FINISH;
          endcase
        end
      end
      easpf_pkg::ST_LOAD: state_next = easpf_pkg::ST_FINISH;
      easpf_pkg::ST_SCAN: begin
        if (last_ch) begin
          state_next = easpf_pkg::ST_FINISH;
        end
      end
      easpf_pkg::ST_TICK_CH: begin
        if (ch_need) begin
          state_next = easpf_pkg::ST_TICK_WAIT;
        end else if (last_ch) begin
          state_next = easpf_pkg::ST_TICK_END;
        end
      end
      easpf_pkg::ST_TICK_WAIT: begin
        if (mod_rsp.done) begin
          state_next = last_ch ? easpf_pkg::ST_TICK_END : easpf_pkg::ST_TICK_CH;
        end
      end
      easpf_pkg::ST_TICK_END: state_next = easpf_pkg::ST_FINISH;
      easpf_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = easpf_pkg::ST_IDLE;
        end
      end
      default: state_next = easpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall       = 1'b1;
    mod_req.start    = 1'b0;
    mod_req.dividend = frame_counter;
    mod_req.divisor  = toggle_period[idx];
    apply_ch         = 1'b0;
    toggle_hit       = 1'b0;
    result_load      = 1'b0;
    unique case (state)
      easpf_pkg::ST_IDLE: item_stall = 1'b0;
      easpf_pkg::ST_TICK_CH: begin
        mod_req.start = ch_need;
        apply_ch      = !ch_need;
      end
      easpf_pkg::ST_TICK_WAIT: begin
        apply_ch   = mod_rsp.done;
        toggle_hit = mod_rsp.done && mod_rsp.rem_zero;
      end
      easpf_pkg::ST_FINISH: result_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= easpf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        toggle_period[i] <= easpf_pkg::PERIOD_W'(1);
        frames_left[i]   <= '0;
      end
      direction_bits <= '0;
      motor_mask     <= '0;
      frame_counter  <= '0;
      word_reg       <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (accept) begin
        cur_op     <= op;
        cur_motor  <= motor;
        cur_steps  <= $unsigned(step_count);
        cur_period <= period;
        idx        <= '0;
        scan_max   <= '0;
        flag_valid <= 1'b0;
        flag_done  <= 1'b0;
      end

      if (state == easpf_pkg::ST_LOAD && cur_op == easpf_pkg::OP_LOAD && motor_ok) begin
        if (cur_steps != '0) begin
          direction_bits[ld_ch] <= cur_steps[easpf_pkg::STEP_W-1];
        end
        toggle_period[ld_ch] <= eff_period;
        frames_left[ld_ch]   <= {prod[easpf_pkg::COUNT_W-2:0], 1'b0};
        motor_mask[ld_ch]    <= 1'b1;
      end

      if (state == easpf_pkg::ST_SCAN) begin
        scan_max <= scan_val;
        idx      <= idx + 1'b1;
        if (last_ch) begin
          frame_counter <= scan_val;
          word_reg      <= '0;
          if (scan_val == '0) begin
            motor_mask <= '0;
          end
        end
      end

      if (apply_ch) begin
        word_reg <= (word_reg | (easpf_pkg::WORD_W'(direction_bits[idx]) << dir_pos))
                    ^ (easpf_pkg::WORD_W'(toggle_hit) << step_pos);
        if (frames_left[idx] != '0) begin
          frames_left[idx] <= frames_left[idx] - 1'b1;
        end
        idx <= idx + 1'b1;
      end

      if (state == easpf_pkg::ST_TICK_END) begin
        frame_counter <= frame_counter - 1'b1;
        flag_valid    <= 1'b1;
        if (frame_counter == easpf_pkg::COUNT_W'(1)) begin
          flag_done  <= 1'b1;
          motor_mask <= '0;
        end
      end

      if (result_load) begin
        result_valid <= 1'b1;
        frame_word   <= word_reg;
        frame_valid  <= flag_valid;
        run_done     <= flag_done;
        active_mask  <= easpf_pkg::MASK_W'(motor_mask);
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_done_has_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid && run_done |-> frame_valid)
    else $error("Last frame of a run reported without a frame word.");

  a_done_clears_mask: assert property (@(posedge clk) disable iff (rst)
    result_valid && run_done |-> active_mask == '0)
    else $error("Active mask not cleared at the end of a run.");

  a_mod_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> state == easpf_pkg::ST_TICK_WAIT)
    else $error("Remainder unit finished outside a tick wait.");

  a_mod_start_idle: assert property (@(posedge clk) disable iff (rst)
    mod_req.start |=> !mod_rsp.done)
    else $error("Remainder unit finished one cycle after being started.");

endmodule

[rtl/easpf_mod_unit.sv]
// Bit-serial restoring remainder unit that reports whether the remainder is zero.
module easpf_mod_unit (
  input  logic                clk,
  input  logic                rst,
  input  easpf_pkg::mod_req_t req,
  output easpf_pkg::mod_rsp_t rsp
);

  logic [easpf_pkg::COUNT_W-1:0]    dvd;
  logic [easpf_pkg::PERIOD_W-1:0]   dvs;
  logic [easpf_pkg::PERIOD_W-1:0]   rem;
  logic [easpf_pkg::STEP_CNT_W-1:0] cnt;
  logic                             busy;
  logic                             done;
  logic [easpf_pkg::PERIOD_W:0]     rem_sh;
  logic                             fits;

  always_comb begin
    rem_sh = {rem, dvd[easpf_pkg::COUNT_W-1]};
    fits   = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= easpf_pkg::PERIOD_W'(rem_sh - {1'b0, dvs});
        end else begin
          rem <= rem_sh[easpf_pkg::PERIOD_W-1:0];
        end
        dvd <= {dvd[easpf_pkg::COUNT_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == easpf_pkg::STEP_CNT_W'(easpf_pkg::COUNT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.rem_zero = (rem == '0);

endmodule

[dv/tb_eight_axis_step_pulse_framer.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the eight-axis step pulse framer: directed and random traffic.
module tb_eight_axis_step_pulse_framer;

  localparam int NCH = easpf_pkg::NUM_MOTORS_DEFAULT;
  localparam logic [easpf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 1130;
  localparam int BACK_TO_BACK_ITEMS = 120;
  localparam int MAX_RUN_TICKS = 80;
  localparam int MAX_PRINTED = 50;

  typedef struct packed {
    logic [easpf_pkg::WORD_W-1:0] word;
    logic                         fvalid;
    logic                         done;
    logic [easpf_pkg::MASK_W-1:0] mask;
  } frame_result_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                item_valid = 1'b0;
  logic                                item_stall;
  logic [easpf_pkg::OP_W-1:0]          op = easpf_pkg::OP_TICK;
  logic [easpf_pkg::MOTOR_W-1:0]       motor = '0;
  logic signed [easpf_pkg::STEP_W-1:0] step_count = '0;
  logic [easpf_pkg::PERIOD_W-1:0]      period = '0;
  logic                                result_valid;
  logic                                result_stall = 1'b0;
  logic [easpf_pkg::WORD_W-1:0]        frame_word;
  logic                                frame_valid;
  logic                                run_done;
  logic [easpf_pkg::MASK_W-1:0]        active_mask;

  logic [easpf_pkg::PERIOD_W-1:0] pred_period [NCH];
  logic [easpf_pkg::COUNT_W-1:0]  pred_frames_left [NCH];
  logic [easpf_pkg::MASK_W-1:0]   pred_dir;
  logic [easpf_pkg::MASK_W-1:0]   pred_mask;
  logic [easpf_pkg::COUNT_W-1:0]  pred_counter;
  logic [easpf_pkg::WORD_W-1:0]   pred_word;

  frame_result_t pending_frames[$];
  int mismatch_count = 0;
  int sent_count = 0;
  int frames_seen = 0;
  int runs_finished = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  eight_axis_step_pulse_framer u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void reset_predictor();
    for (int i = 0; i < NCH; i++) begin
      pred_period[i] = easpf_pkg::PERIOD_W'(1);
      pred_frames_left[i] = '0;
    end
    pred_dir = '0;
    pred_mask = '0;
    pred_counter = '0;
    pred_word = '0;
  endfunction

  function automatic frame_result_t advance_framer(
      input logic [easpf_pkg::OP_W-1:0] code,
      input logic [easpf_pkg::MOTOR_W-1:0] ch,
      input logic [easpf_pkg::STEP_W-1:0] steps,
      input logic [easpf_pkg::PERIOD_W-1:0] per);
    frame_result_t res;
    logic [easpf_pkg::STEP_W-1:0] magnitude;
    logic [easpf_pkg::COUNT_W-1:0] longest;
    res = '0;
    case (code)
      easpf_pkg::OP_LOAD: begin
        if (steps != '0) pred_dir[ch] = steps[easpf_pkg::STEP_W-1];
        if (per != '0) pred_period[ch] = per;
        magnitude = steps[easpf_pkg::STEP_W-1] ? -steps : steps;
        pred_frames_left[ch] = easpf_pkg::COUNT_W'(magnitude) *
                               easpf_pkg::COUNT_W'(pred_period[ch]) * 2;
        pred_mask[ch] = 1'b1;
      end
      easpf_pkg::OP_START: begin
        longest = '0;
        for (int i = 0; i < NCH; i++)
          if (pred_frames_left[i] > longest) longest = pred_frames_left[i];
        pred_counter = longest;
        pred_word = '0;
        if (longest == '0) pred_mask = '0;
      end
      easpf_pkg::OP_TICK: begin
        if (pred_counter != '0) begin
          for (int i = 0; i < NCH; i++) begin
            pred_word[2*i] = pred_word[2*i] | pred_dir[i];
            if (pred_period[i] != '0 &&
                pred_counter % easpf_pkg::COUNT_W'(pred_period[i]) == '0 &&
                pred_frames_left[i] != '0)
              pred_word[2*i+1] = ~pred_word[2*i+1];
            if (pred_frames_left[i] != '0) pred_frames_left[i] = pred_frames_left[i] - 1;
          end
          res.fvalid = 1'b1;
          pred_counter = pred_counter - 1;
          if (pred_counter == '0) begin
            res.done = 1'b1;
            pred_mask = '0;
          end
        end
      end
      default: ;
    endcase
    res.word = pred_word;
    res.mask = pred_mask;
    return res;
  endfunction

  function automatic logic [easpf_pkg::STEP_W-1:0] few_steps();
    return easpf_pkg::STEP_W'($urandom_range(0, 6) - 3);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    // Only the first few are printed so that a badly broken block cannot flood the log.
    if (mismatch_count < MAX_PRINTED)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_transaction(input logic [easpf_pkg::OP_W-1:0] code,
                                  input logic [easpf_pkg::MOTOR_W-1:0] ch,
                                  input logic [easpf_pkg::STEP_W-1:0] steps,
                                  input logic [easpf_pkg::PERIOD_W-1:0] per);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= code;
    motor <= ch;
    step_count <= steps;
    period <= per;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_frames.push_back(advance_framer(code, ch, steps, per));
    sent_count++;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (!rst && !quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 14);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("result with no transaction pending", 32'(frame_word), 32'd0);
      end else begin
        want = pending_frames.pop_front();
        if (frame_word !== want.word)
          report_mismatch("frame_word", 32'(frame_word), 32'(want.word));
        if (frame_valid !== want.fvalid)
          report_mismatch("frame_valid", 32'(frame_valid), 32'(want.fvalid));
        if (run_done !== want.done)
          report_mismatch("run_done", 32'(run_done), 32'(want.done));
        if (active_mask !== want.mask)
          report_mismatch("active_mask", 32'(active_mask), 32'(want.mask));
        if (want.fvalid) frames_seen++;
        if (want.done) runs_finished++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("No transaction for %0d cycles; giving up.", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_idle_items();
    send_transaction(easpf_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000);
    send_transaction(OP_UNUSED, 3'd5, 16'h8001, 16'hffff);
    send_transaction(easpf_pkg::OP_LOAD, 3'd2, 16'h0000, 16'h0000);
    send_transaction(easpf_pkg::OP_START, 3'd0, 16'h0000, 16'h0000);
    send_transaction(easpf_pkg::OP_TICK, 3'd7, 16'hffff, 16'hffff);
  endtask

  task automatic test_load_extremes();
    send_transaction(easpf_pkg::OP_LOAD, 3'd0, 16'h8000, 16'hffff);
    send_transaction(easpf_pkg::OP_LOAD, 3'd7, 16'h7fff, 16'h0000);
    send_transaction(easpf_pkg::OP_LOAD, 3'd3, 16'hffff, 16'h0001);
    send_transaction(easpf_pkg::OP_LOAD, 3'd5, 16'h0001, 16'h0003);
    send_transaction(easpf_pkg::OP_START, 3'd0, 16'h0000, 16'h0000);
    repeat (4) send_transaction(easpf_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000);
    send_transaction(easpf_pkg::OP_LOAD, 3'd6, 16'hfffe, 16'h0002);
    send_transaction(easpf_pkg::OP_LOAD, 3'd3, 16'h0000, 16'h0000);
    repeat (3) send_transaction(easpf_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000);
    // The long channels are emptied so that the following start opens no run.
    send_transaction(easpf_pkg::OP_LOAD, 3'd0, 16'h0000, 16'h0001);
    send_transaction(easpf_pkg::OP_LOAD, 3'd5, 16'h0000, 16'h0001);
    send_transaction(easpf_pkg::OP_LOAD, 3'd6, 16'h0000, 16'h0001);
    send_transaction(easpf_pkg::OP_LOAD, 3'd7, 16'h0000, 16'h0001);
    send_transaction(easpf_pkg::OP_START, 3'd0, 16'h0000, 16'h0000);
  endtask

  task automatic test_random_runs(input int quota);
    int target;
    int ticks;
    int cutoff;
    target = sent_count + quota;
    while (sent_count < target) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 6))
          send_transaction(easpf_pkg::OP_W'($urandom_range(0, 3)),
                           easpf_pkg::MOTOR_W'($urandom),
                           easpf_pkg::STEP_W'($urandom), easpf_pkg::PERIOD_W'($urandom));
      end else begin
        for (int m = 0; m < NCH; m++) begin
          if ($urandom_range(0, 3) == 0)
            send_transaction(easpf_pkg::OP_LOAD, easpf_pkg::MOTOR_W'(m), '0,
                             easpf_pkg::PERIOD_W'($urandom_range(1, 4)));
          else
            send_transaction(easpf_pkg::OP_LOAD, easpf_pkg::MOTOR_W'(m), few_steps(),
                             ($urandom_range(0, 7) == 0) ? '0
                             : easpf_pkg::PERIOD_W'($urandom_range(1, 4)));
        end
        if ($urandom_range(0, 9) != 0)
          send_transaction(easpf_pkg::OP_START, easpf_pkg::MOTOR_W'($urandom),
                           easpf_pkg::STEP_W'($urandom), easpf_pkg::PERIOD_W'($urandom));
        ticks = 0;
        cutoff = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : MAX_RUN_TICKS;
        while (pred_counter != '0 && ticks < cutoff) begin
          if ($urandom_range(0, 15) == 0)
            send_transaction(easpf_pkg::OP_LOAD, easpf_pkg::MOTOR_W'($urandom), few_steps(),
                             easpf_pkg::PERIOD_W'($urandom_range(0, 4)));
          send_transaction(easpf_pkg::OP_TICK, easpf_pkg::MOTOR_W'($urandom),
                           easpf_pkg::STEP_W'($urandom), easpf_pkg::PERIOD_W'($urandom));
          ticks++;
        end
      end
    end
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    test_random_runs(BACK_TO_BACK_ITEMS);
  endtask

  initial begin
    reset_predictor();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_idle_items();
    test_load_extremes();
    test_random_runs(RANDOM_ITEMS);
    test_back_to_back();
    item_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d transactions covering loads, starts, ticks and unused codes.", sent_count);
    $display("Checked %0d frame words over %0d completed runs; %0d mismatches.",
             frames_seen, runs_finished, mismatch_count);
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
